// File: rtl/core/ofip_pkg.sv
// Shared types and constants for the OBJ face index parser.
`timescale 1ns / 1ps

package ofip_pkg;

  // Character codes the parser reacts to
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_F     = 8'd102;

  // Width of one index value
  localparam int unsigned IDX_W = 32;

  // Command queue between front and back
  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_AW    = 2;
  localparam int unsigned CQ_CW    = 3;

  // Byte class of a face-line byte
  typedef enum logic [2:0] {
    OP_NL,
    OP_SPACE,
    OP_SLASH,
    OP_DIGIT,
    OP_SIGN,
    OP_OTHER
  } cmd_op_e;

  // One classified byte handed to the back end
  typedef struct packed {
    cmd_op_e    op;
    logic [3:0] digit;
    logic       minus;
  } cmd_t;

endpackage

// File: rtl/core/ofip_front.sv
// Front end: tracks line type and classifies face-line bytes into commands.
`timescale 1ns / 1ps

module ofip_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    char_byte_i,
  output logic          cmd_push_o,
  output ofip_pkg::cmd_t cmd_o,
  input  logic          cmd_full_i
);
  import ofip_pkg::*;

  // Line mode codes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_FACE  = 2'd1;
  localparam logic [1:0] MODE_SKIP  = 2'd2;

  logic [1:0] mode_q, mode_d;
  logic       accept;

  assign in_stall_o = cmd_full_i;
  assign accept     = in_valid_i && !cmd_full_i;

  // Byte classification
  always_comb begin
    cmd_o.digit = char_byte_i[3:0];
    cmd_o.minus = (char_byte_i == CH_MINUS);
    if (char_byte_i == CH_NL) begin
      cmd_o.op = OP_NL;
    end else if (char_byte_i == CH_SPACE) begin
      cmd_o.op = OP_SPACE;
    end else if (char_byte_i == CH_SLASH) begin
      cmd_o.op = OP_SLASH;
    end else if (char_byte_i inside {[CH_ZERO:CH_NINE]}) begin
      cmd_o.op = OP_DIGIT;
    end else if (char_byte_i inside {CH_PLUS, CH_MINUS}) begin
      cmd_o.op = OP_SIGN;
    end else begin
      cmd_o.op = OP_OTHER;
    end
  end

  // Line mode tracking; only bytes of a face line body go to the queue
  always_comb begin
    mode_d     = mode_q;
    cmd_push_o = 1'b0;
    if (accept) begin
      case (mode_q)
        MODE_START: begin
          if (char_byte_i == CH_F) begin
            mode_d = MODE_FACE;
          end else if (char_byte_i != CH_NL) begin
            mode_d = MODE_SKIP;
          end
        end
        MODE_FACE: begin
          cmd_push_o = 1'b1;
          if (char_byte_i == CH_NL) begin
            mode_d = MODE_START;
          end
        end
        default: begin
          if (char_byte_i == CH_NL) begin
            mode_d = MODE_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
    end else begin
      mode_q <= mode_d;
    end
  end

endmodule

// File: rtl/core/ofip_cmd_fifo.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module ofip_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ofip_pkg::cmd_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  output ofip_pkg::cmd_t data_o,
  input  logic           pop_i
);
  import ofip_pkg::*;

  cmd_t             entry_q [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CQ_CW-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CQ_CW'(CQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/ofip_back.sv
// Back end: field accumulation, token assembly, hold-back and output register.
`timescale 1ns / 1ps

module ofip_back #(
  parameter int unsigned FIELD_MAX_CHARS = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  ofip_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ofip_pkg::IDX_W-1:0] vertex_o,
  output logic [ofip_pkg::IDX_W-1:0] texcoord_o,
  output logic [ofip_pkg::IDX_W-1:0] normal_o,
  output logic                       last_o
);
  import ofip_pkg::*;

  localparam int unsigned LEN_W = $clog2(FIELD_MAX_CHARS + 1);

  // Field phase codes
  localparam logic [1:0] PH_BEFORE  = 2'd0;
  localparam logic [1:0] PH_DIGITS  = 2'd1;
  localparam logic [1:0] PH_STOPPED = 2'd2;

  logic             open_q, open_d;
  logic             held_valid_q, held_valid_d;
  logic [1:0]       num_q, num_d;
  logic [IDX_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [1:0]       phase_q, phase_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] tok_q [3];
  logic [IDX_W-1:0] tok_d [3];
  logic [IDX_W-1:0] held_q [3];
  logic [IDX_W-1:0] held_d [3];

  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_v_q, out_t_q, out_n_q;
  logic             out_last_q;

  // Effective state: a closed token reads as freshly begun
  logic [1:0]       e_num;
  logic [IDX_W-1:0] e_acc;
  logic             e_neg;
  logic [1:0]       e_phase;
  logic [LEN_W-1:0] e_len;
  logic [IDX_W-1:0] e_tok [3];
  logic [IDX_W-1:0] fin_val;
  logic [IDX_W-1:0] fin_tok [3];
  logic [IDX_W-1:0] acc_step;
  logic             emit;
  logic             emit_last;
  logic [IDX_W-1:0] emit_tok [3];

  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || !out_stall_i);

  // Finished field value and token with it stored
  always_comb begin
    e_num    = open_q ? num_q : 2'd0;
    e_acc    = open_q ? acc_q : '0;
    e_neg    = open_q ? neg_q : 1'b0;
    e_phase  = open_q ? phase_q : PH_BEFORE;
    e_len    = open_q ? len_q : '0;
    for (int i = 0; i < 3; i++) begin
      e_tok[i]   = open_q ? tok_q[i] : '0;
      fin_tok[i] = e_tok[i];
    end
    fin_val = e_neg ? (IDX_W'(0) - e_acc) : e_acc;
    if (e_num != 2'd3) begin
      fin_tok[e_num] = fin_val;
    end
    acc_step = (e_acc << 3) + (e_acc << 1) + IDX_W'(cmd_i.digit);
  end

  // Command execution
  always_comb begin
    open_d       = open_q;
    held_valid_d = held_valid_q;
    num_d        = num_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    phase_d      = phase_q;
    len_d        = len_q;
    tok_d        = tok_q;
    held_d       = held_q;
    emit         = 1'b0;
    emit_last    = 1'b0;
    emit_tok     = held_q;
    if (cmd_pop_o) begin
      case (cmd_i.op)
        OP_NL: begin
          if (open_q) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            emit_tok  = fin_tok;
          end else if (held_valid_q) begin
            emit      = 1'b1;
            emit_last = 1'b1;
          end
          open_d       = 1'b0;
          held_valid_d = 1'b0;
          num_d        = 2'd0;
          acc_d        = '0;
          neg_d        = 1'b0;
          phase_d      = PH_BEFORE;
          len_d        = '0;
        end
        OP_SPACE: begin
          if (open_q) begin
            held_d       = fin_tok;
            held_valid_d = 1'b1;
            open_d       = 1'b0;
          end
        end
        default: begin
          // First byte of a token releases the held triplet
          if (!open_q && held_valid_q) begin
            emit         = 1'b1;
            held_valid_d = 1'b0;
          end
          open_d  = 1'b1;
          num_d   = e_num;
          acc_d   = e_acc;
          neg_d   = e_neg;
          phase_d = e_phase;
          len_d   = e_len;
          tok_d   = e_tok;
          if (cmd_i.op == OP_SLASH) begin
            tok_d   = fin_tok;
            acc_d   = '0;
            neg_d   = 1'b0;
            phase_d = PH_BEFORE;
            len_d   = '0;
            num_d   = (e_num == 2'd3) ? 2'd3 : e_num + 2'd1;
          end else if (e_num != 2'd3 && e_len < LEN_W'(FIELD_MAX_CHARS)) begin
            len_d = e_len + 1'b1;
            if (e_phase != PH_STOPPED) begin
              if (cmd_i.op == OP_DIGIT) begin
                acc_d   = acc_step;
                phase_d = PH_DIGITS;
              end else if (e_phase == PH_BEFORE && cmd_i.op == OP_SIGN) begin
                neg_d   = cmd_i.minus;
                phase_d = PH_DIGITS;
              end else begin
                phase_d = PH_STOPPED;
              end
            end
          end
        end
      endcase
    end
  end

  // Output register holds a result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      open_q       <= open_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    acc_q   <= acc_d;
    neg_q   <= neg_d;
    phase_q <= phase_d;
    len_q   <= len_d;
    tok_q   <= tok_d;
    held_q  <= held_d;
    if (emit) begin
      out_v_q    <= emit_tok[0];
      out_t_q    <= emit_tok[1];
      out_n_q    <= emit_tok[2];
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = out_v_q;
  assign texcoord_o  = out_t_q;
  assign normal_o    = out_n_q;
  assign last_o      = out_last_q;

endmodule

// File: rtl/core/obj_face_index_parser_unit.sv
// Top level of the OBJ face index parser: front, command queue, back.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid_i/in_stall_o  char_byte_i
//   out      source     out_valid_o/out_stall_i vertex/texcoord/normal_index_o,
//                                               last_of_face_o
//
// One byte per cycle sustained while the command queue is not full. The front
// is combinational: an accepted byte is written into the four-entry command
// queue, and the back pops it from there into its output register, from which
// the result is offered. Only the queue fill sets in_stall_o; the back pops
// whenever its output register is empty or being taken. Reset is
// asynchronous and clears all control state; no clearing pass is needed.
`timescale 1ns / 1ps

module obj_face_index_parser_unit #(
  parameter int unsigned FIELD_MAX_CHARS = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        char_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ofip_pkg::IDX_W-1:0] vertex_index_o,
  output logic signed [ofip_pkg::IDX_W-1:0] texcoord_index_o,
  output logic signed [ofip_pkg::IDX_W-1:0] normal_index_o,
  output logic                              last_of_face_o
);
  import ofip_pkg::*;

  logic             push, full, q_valid, pop;
  cmd_t             push_cmd, q_cmd;
  logic [IDX_W-1:0] v_raw, t_raw, n_raw;

  ofip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_byte_i (char_byte_i),
    .cmd_push_o  (push),
    .cmd_o       (push_cmd),
    .cmd_full_i  (full)
  );

  ofip_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .valid_o     (q_valid),
    .data_o      (q_cmd),
    .pop_i       (pop)
  );

  ofip_back #(
    .FIELD_MAX_CHARS (FIELD_MAX_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .vertex_o    (v_raw),
    .texcoord_o  (t_raw),
    .normal_o    (n_raw),
    .last_o      (last_of_face_o)
  );

  assign vertex_index_o   = $signed(v_raw);
  assign texcoord_index_o = $signed(t_raw);
  assign normal_index_o   = $signed(n_raw);

endmodule

// File: rtl/core/ofip_checker.sv
// Port-level checks for the OBJ face index parser, bound to the top level.
`timescale 1ns / 1ps

module ofip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  char_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] vertex_index_o,
  input logic [31:0] texcoord_index_o,
  input logic [31:0] normal_index_o,
  input logic        last_of_face_o
);
  import ofip_pkg::*;

  logic       in_xfer, out_xfer, last_xfer, nl_xfer;
  logic [7:0] byte_cnt_q, nl_cnt_q;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_o && !out_stall_i;
  assign last_xfer = out_xfer && last_of_face_o;
  assign nl_xfer   = in_xfer && (char_byte_i == CH_NL);

  // Outstanding bytes and newlines; saturated counts stay put
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      nl_cnt_q   <= '0;
    end else begin
      if (byte_cnt_q != 8'hff) begin
        byte_cnt_q <= byte_cnt_q + 8'(in_xfer) - 8'(out_xfer);
      end
      if (nl_cnt_q != 8'hff) begin
        nl_cnt_q <= nl_cnt_q + 8'(nl_xfer) - 8'(last_xfer);
      end
    end
  end

  // Every result transfer is caused by an earlier accepted byte
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> byte_cnt_q != 8'd0)
    else $error("result transfer with no outstanding input byte");

  // A final triplet needs a newline accepted beforehand
  a_last_needs_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_xfer |-> nl_cnt_q != 8'd0)
    else $error("last_of_face transfer without a preceding newline");

  // Nothing is offered straight out of reset
  a_quiet_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vertex_index_o)
      && $stable(texcoord_index_o) && $stable(normal_index_o)
      && $stable(last_of_face_o))
    else $error("stalled result changed");

endmodule

bind obj_face_index_parser_unit ofip_checker u_ofip_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .char_byte_i      (char_byte_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .vertex_index_o   (vertex_index_o),
  .texcoord_index_o (texcoord_index_o),
  .normal_index_o   (normal_index_o),
  .last_of_face_o   (last_of_face_o)
);

// File: tb/sv/tb_obj_face_index_parser_unit.sv
// Self-checking testbench for the OBJ face index parser unit.
`timescale 1ns / 1ps

module tb_obj_face_index_parser_unit;
  import ofip_pkg::*;

  localparam int unsigned FieldMaxChars = 31;
  localparam int unsigned FaceBytesWanted = 1800;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned ShownFailures = 10;

  typedef enum logic [1:0] {
    LINE_START,
    LINE_FACE,
    LINE_SKIP
  } line_mode_e;

  typedef enum logic [1:0] {
    NUM_BEFORE,
    NUM_DIGITS,
    NUM_STOPPED
  } num_phase_e;

  typedef struct packed {
    logic [IDX_W-1:0] vertex;
    logic [IDX_W-1:0] texcoord;
    logic [IDX_W-1:0] normal;
    logic             last_of_face;
  } triplet_t;

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [7:0]              char_byte_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [IDX_W-1:0] vertex_index_o;
  logic signed [IDX_W-1:0] texcoord_index_o;
  logic signed [IDX_W-1:0] normal_index_o;
  logic                    last_of_face_o;

  // Text still to send and triplets still owed by the block
  logic [7:0] text_q[$];
  triplet_t   triplet_q[$];

  int unsigned text_total = 1;
  int unsigned bytes_taken = 0;
  int unsigned fail_count = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned stim_stage;

  // Parser state as the block should hold it
  line_mode_e                cur_line = LINE_START;
  logic [1:0]                fld_num = '0;
  logic [IDX_W-1:0]          fld_mag = '0;
  logic                      fld_neg = 1'b0;
  num_phase_e                fld_phase = NUM_BEFORE;
  int unsigned               fld_len = 0;
  logic                      tok_open = 1'b0;
  logic [2:0][IDX_W-1:0]     tok_val = '0;
  logic                      held_ok = 1'b0;
  logic [2:0][IDX_W-1:0]     held_val = '0;

  obj_face_index_parser_unit #(
    .FIELD_MAX_CHARS(FieldMaxChars)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_byte_i     (char_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vertex_index_o  (vertex_index_o),
    .texcoord_index_o(texcoord_index_o),
    .normal_index_o  (normal_index_o),
    .last_of_face_o  (last_of_face_o)
  );

  // Thirds of the run: receiver stalls more, then sender idles more, then neither
  assign stim_stage = (bytes_taken * 3 < text_total) ? 0 :
                      (bytes_taken * 3 < 2 * text_total) ? 1 : 2;

  // ---------------------------------------------------------------------------
  // Index prediction
  // ---------------------------------------------------------------------------

  function automatic void field_reset();
    fld_mag = '0;
    fld_neg = 1'b0;
    fld_phase = NUM_BEFORE;
    fld_len = 0;
  endfunction

  // Store the finished field into its slot of the token
  function automatic void field_close();
    if (fld_num < 3) tok_val[fld_num] = fld_neg ? (IDX_W'(0) - fld_mag) : fld_mag;
    field_reset();
  endfunction

  function automatic void owe_triplet(input logic [2:0][IDX_W-1:0] vals, input logic last);
    triplet_t t;
    t.vertex = vals[0];
    t.texcoord = vals[1];
    t.normal = vals[2];
    t.last_of_face = last;
    triplet_q.push_back(t);
  endfunction

  // atoi-style step: sign once, then digits, anything else stops the field
  function automatic void field_char(input logic [7:0] c);
    if (fld_num < 3 && fld_len < FieldMaxChars) begin
      fld_len++;
      if (fld_phase != NUM_STOPPED) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          fld_mag = fld_mag * IDX_W'(10) + IDX_W'(c - CH_ZERO);
          fld_phase = NUM_DIGITS;
        end else if (fld_phase == NUM_BEFORE && (c == CH_PLUS || c == CH_MINUS)) begin
          fld_neg = (c == CH_MINUS);
          fld_phase = NUM_DIGITS;
        end else begin
          fld_phase = NUM_STOPPED;
        end
      end
    end
  endfunction

  function automatic void face_char(input logic [7:0] c);
    if (c == CH_NL) begin
      // open token goes out last, else the held one
      if (tok_open) begin
        field_close();
        owe_triplet(tok_val, 1'b1);
      end else if (held_ok) begin
        owe_triplet(held_val, 1'b1);
      end
      tok_open = 1'b0;
      held_ok = 1'b0;
      fld_num = '0;
      field_reset();
      cur_line = LINE_START;
    end else if (c == CH_SPACE) begin
      if (tok_open) begin
        field_close();
        held_val = tok_val;
        held_ok = 1'b1;
        tok_open = 1'b0;
      end
    end else begin
      // first byte of a token releases the held triplet
      if (!tok_open) begin
        if (held_ok) begin
          owe_triplet(held_val, 1'b0);
          held_ok = 1'b0;
        end
        tok_open = 1'b1;
        fld_num = '0;
        tok_val = '0;
        field_reset();
      end
      if (c == CH_SLASH) begin
        field_close();
        if (fld_num < 3) fld_num++;
      end else begin
        field_char(c);
      end
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    case (cur_line)
      LINE_START: begin
        if (c == CH_F) cur_line = LINE_FACE;
        else if (c != CH_NL) cur_line = LINE_SKIP;
      end
      LINE_SKIP: begin
        if (c == CH_NL) cur_line = LINE_START;
      end
      default: face_char(c);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void put_spaces(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) text_q.push_back(CH_SPACE);
  endfunction

  function automatic void put_digits(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  // Any byte that is not a separator inside a face line
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_NL || c == CH_SPACE || c == CH_SLASH);
    return c;
  endfunction

  function automatic void put_field();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // empty
    end else if (pick < 45) begin
      put_digits($urandom_range(1, 3));
    end else if (pick < 58) begin
      text_q.push_back(CH_MINUS);
      put_digits($urandom_range(1, 3));
    end else if (pick < 64) begin
      text_q.push_back(CH_PLUS);
      put_digits($urandom_range(1, 3));
    end else if (pick < 69) begin
      text_q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
    end else if (pick < 74) begin
      // near or past the counted length
      if ($urandom_range(1)) text_q.push_back(CH_MINUS);
      put_digits($urandom_range(FieldMaxChars - 2, FieldMaxChars + 8));
    end else if (pick < 82) begin
      // may wrap past 32 bits
      if ($urandom_range(1)) text_q.push_back(CH_MINUS);
      put_digits($urandom_range(10, 14));
    end else if (pick < 90) begin
      put_digits($urandom_range(1, 3));
      text_q.push_back(junk_char());
      put_digits($urandom_range(0, 2));
    end else begin
      text_q.push_back(junk_char());
      if ($urandom_range(1)) put_digits(1);
    end
  endfunction

  function automatic void put_token();
    int unsigned nfields;
    nfields = ($urandom_range(9) == 0) ? $urandom_range(4, 5) : $urandom_range(1, 3);
    for (int unsigned i = 0; i < nfields; i++) begin
      if (i != 0) text_q.push_back(CH_SLASH);
      put_field();
    end
  endfunction

  function automatic void put_face_line();
    int unsigned ntok;
    ntok = $urandom_range(0, 6);
    text_q.push_back(CH_F);
    for (int unsigned i = 0; i < ntok; i++) begin
      if (i != 0 || $urandom_range(9) != 0) put_spaces($urandom_range(1, 3));
      put_token();
    end
    if ($urandom_range(3) == 0) put_spaces($urandom_range(1, 2));
    if ($urandom_range(7) == 0) text_q.push_back(8'd13);
    text_q.push_back(CH_NL);
  endfunction

  // Other lines: vertex data, a face line hidden by a leading space, an empty line, raw noise
  function automatic void put_other_line();
    int unsigned pick;
    pick = $urandom_range(3);
    case (pick)
      0: put_str("v 1.5 -2 0.25");
      1: put_str(" f 1 2 3");
      2: put_str("");
      default: begin
        for (int unsigned i = 0; i < $urandom_range(1, 12); i++) begin
          logic [7:0] c;
          do c = 8'($urandom_range(255)); while (c == CH_NL);
          text_q.push_back(c);
        end
      end
    endcase
    text_q.push_back(CH_NL);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, limit
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Byte driver: predicts on each transfer, then offers the next byte
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : byte_driver
    logic        took;
    int unsigned idle_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      char_byte_i <= '0;
    end else begin
      took = in_valid_i && !in_stall_o;
      idle_pct = (stim_stage == 0) ? 24 : (stim_stage == 1) ? 57 : 0;
      if (took) begin
        parse_char(char_byte_i);
        bytes_taken <= bytes_taken + 1;
      end
      if (in_valid_i && !took) begin
        // stalled: hold the payload
      end else if (text_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        char_byte_i <= text_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stall: random, plus one long hold-off while bytes keep coming
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_stall
    int unsigned idle_pct;
    idle_pct = (stim_stage == 0) ? 57 : (stim_stage == 1) ? 24 : 0;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (!hold_done && stim_stage == 2) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= ShownFailures) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin : result_monitor
    triplet_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (triplet_q.size() == 0) begin
        note_failure($sformatf("unexpected triplet %0d/%0d/%0d last %b",
                               vertex_index_o, texcoord_index_o, normal_index_o,
                               last_of_face_o));
      end else begin
        want = triplet_q.pop_front();
        if (vertex_index_o !== want.vertex || texcoord_index_o !== want.texcoord ||
            normal_index_o !== want.normal || last_of_face_o !== want.last_of_face) begin
          note_failure($sformatf(
            "triplet mismatch: expected %0d/%0d/%0d last %b, got %0d/%0d/%0d last %b",
            $signed(want.vertex), $signed(want.texcoord), $signed(want.normal),
            want.last_of_face, vertex_index_o, texcoord_index_o, normal_index_o,
            last_of_face_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned face_bytes;
    int unsigned mark;
    face_bytes = 0;

    // Empty face line; leading space hides an 'f'
    put_str("f\n");
    put_str(" f\n");
    // Lone sign, signed number, extra fields, NUL and 0xff stopping a field,
    // empty fields, token with missing fields
    put_str("f -/+9/3/8 ");
    text_q.push_back(8'h00);
    text_q.push_back(8'hff);
    put_str("1// 5\n");

    while (face_bytes < FaceBytesWanted) begin
      if ($urandom_range(4) != 0) begin
        mark = text_q.size();
        put_face_line();
        face_bytes += text_q.size() - mark;
      end else begin
        put_other_line();
      end
    end
    text_total = text_q.size();

    while (text_q.size() != 0 || in_valid_i || triplet_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ofip_pkg.sv
rtl/core/ofip_front.sv
rtl/core/ofip_cmd_fifo.sv
rtl/core/ofip_back.sv
rtl/core/obj_face_index_parser_unit.sv
rtl/core/ofip_checker.sv
tb/sv/tb_obj_face_index_parser_unit.sv
